// File: rtl/core/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared widths, constants and beat types for the prewarped bilinear
// transform unit.
// ----------------------------------------------------------------------------
package bbt_pkg;

  // Field formats.
  localparam int COEF_WIDTH = 32;
  localparam int FREQ_WIDTH = 16;
  localparam int IN_FRAC    = COEF_WIDTH / 2;
  localparam int OUT_FRAC   = COEF_WIDTH - 8;
  localparam int NUM_COEF   = 5;

  // Sine and cosine series, Q62 fixed point.
  localparam int          SERIES_ORDER = 25;
  localparam logic [63:0] PI_Q62       = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;

  // Division of a series term by its order, one digit per stage.
  localparam int DIGIT_W     = 16;
  localparam int DIGITS      = 64 / DIGIT_W;
  localparam int ORDER_W     = $clog2(SERIES_ORDER + 1);
  localparam int DIGIT_VAL_W = DIGIT_W + ORDER_W;
  localparam int RECIP_SHIFT = DIGIT_W + 2 * ORDER_W;
  localparam int TERM_LAT    = 2 + DIGITS;

  // Product, term and sum widths of the numerators and the denominator.
  localparam int PROD_W = COEF_WIDTH + 64;
  localparam int TERM_W = PROD_W + 1;
  localparam int SUM_W  = TERM_W + 2;

  // Quotient register and its clamp.
  localparam int                QUOT_W   = COEF_WIDTH + 3;
  localparam logic [QUOT_W-1:0] QUOT_CAP = {2'b01, {(QUOT_W - 2){1'b0}}};
  localparam int                DIV_ITER = SUM_W + OUT_FRAC + 1;

  // Saturation limits of a result coefficient.
  localparam logic [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH - 1){1'b0}}};

  // Cycles from an accepted item to its result strobe.
  localparam int PIPE_LATENCY = 2 + TERM_LAT * SERIES_ORDER + 1 + 6 + 1 + DIV_ITER + 1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SAT      = 2'd1,
    STAT_ZERO_DEN = 2'd2
  } bbt_status_t;

  typedef struct packed {
    logic [FREQ_WIDTH-2:0]        corner_freq;
    logic signed [COEF_WIDTH-1:0] s_num0;
    logic signed [COEF_WIDTH-1:0] s_num1;
    logic signed [COEF_WIDTH-1:0] s_num2;
    logic signed [COEF_WIDTH-1:0] s_den1;
    logic signed [COEF_WIDTH-1:0] s_den2;
  } bbt_in_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] z_num0;
    logic signed [COEF_WIDTH-1:0] z_num1;
    logic signed [COEF_WIDTH-1:0] z_num2;
    logic signed [COEF_WIDTH-1:0] z_den1;
    logic signed [COEF_WIDTH-1:0] z_den2;
    bbt_status_t                  status;
  } bbt_out_t;

  // Numerators and denominator handed to the divider, two's complement.
  typedef struct packed {
    logic                             vld;
    logic [NUM_COEF-1:0][SUM_W-1:0]   num;
    logic [SUM_W-1:0]                 den;
  } bbt_frac_t;

endpackage

// File: rtl/core/bbt_mul64.sv
// ----------------------------------------------------------------------------
// bbt_mul64
// Two-stage unsigned 64 x 64 multiplier built from four 32 x 32 partial
// products; the full product is registered.
// ----------------------------------------------------------------------------
module bbt_mul64 (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0]  pp_r [4];
  logic [127:0] prod_r;

  // Partial products, then their weighted sum.
  always_ff @(posedge clk) begin
    pp_r[0] <= a[31:0] * b[31:0];
    pp_r[1] <= a[31:0] * b[63:32];
    pp_r[2] <= a[63:32] * b[31:0];
    pp_r[3] <= a[63:32] * b[63:32];
    prod_r  <= 128'(pp_r[0]) + (128'(pp_r[1]) << 32) + (128'(pp_r[2]) << 32)
             + (128'(pp_r[3]) << 64);
  end

  assign p = prod_r;

endmodule

// File: rtl/core/bbt_sincos.sv
// ----------------------------------------------------------------------------
// bbt_sincos
// Forms theta = pi * f0 in Q62 and runs the sine and cosine Taylor series,
// one series term per group of pipeline stages.
// ----------------------------------------------------------------------------
module bbt_sincos import bbt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  bbt_in_t     in_coef,
  output logic        out_vld,
  output logic [63:0] sin_q,
  output logic [63:0] cos_q,
  output bbt_in_t     out_coef
);

  typedef struct packed {
    logic        vld;
    logic [63:0] theta;
    logic [63:0] t;
    logic [63:0] sa;
    logic [63:0] ca;
    bbt_in_t     coef;
  } bbt_sc_t;

  localparam int FINAL_PHASE = SERIES_ORDER % 4;

  logic [127:0] theta_prod;
  logic [1:0]   th_vld_r;
  bbt_in_t      th_coef_r [2];
  bbt_sc_t      link [SERIES_ORDER + 1];
  bbt_sc_t      fin_nxt;
  bbt_sc_t      fin_r;

  // Theta is the frequency code times pi, scaled back by FREQ_WIDTH bits, one more than the code width.
  bbt_mul64 u_theta_mul (
    .clk (clk),
    .a   (64'(in_coef.corner_freq)),
    .b   (PI_Q62),
    .p   (theta_prod)
  );

  always_ff @(posedge clk) begin
    th_vld_r     <= {th_vld_r[0], in_vld};
    th_coef_r[0] <= in_coef;
    th_coef_r[1] <= th_coef_r[0];
    if (!rst_n) begin
      th_vld_r <= '0;
    end
  end

  assign link[0] = '{vld:   th_vld_r[1],
                     theta: theta_prod[FREQ_WIDTH +: 64],
                     t:     ONE_Q62,
                     sa:    '0,
                     ca:    ONE_Q62,
                     coef:  th_coef_r[1]};

  // One term per block: multiply by theta, fold the previous term into its
  // sum, then divide by the term order one digit per stage.
  for (genvar g = 1; g <= SERIES_ORDER; g++) begin : g_term
    localparam int PREV_PHASE = (g - 1) % 4;
    localparam logic [RECIP_SHIFT:0] RECIP =
      (RECIP_SHIFT + 1)'(((64'd1 << RECIP_SHIFT) + 64'(g) - 64'd1) / 64'(g));
    localparam logic [DIGIT_VAL_W-1:0] ORDER = DIGIT_VAL_W'(g);

    logic [127:0]        prod;
    bbt_sc_t             acc;
    bbt_sc_t             st_r [2];
    bbt_sc_t             dg_r [DIGITS];
    logic [63:0]         x_r  [DIGITS];
    logic [ORDER_W-1:0]  rem_r [DIGITS];

    bbt_mul64 u_mul (
      .clk (clk),
      .a   (link[g-1].t),
      .b   (link[g-1].theta),
      .p   (prod)
    );

    // The previous term joins its series with the usual alternating sign.
    always_comb begin
      acc = link[g-1];
      if (g > 1) begin
        case (PREV_PHASE)
          1:       acc.sa = link[g-1].sa + link[g-1].t;
          2:       acc.ca = link[g-1].ca - link[g-1].t;
          3:       acc.sa = link[g-1].sa - link[g-1].t;
          default: acc.ca = link[g-1].ca + link[g-1].t;
        endcase
      end
    end

    always_ff @(posedge clk) begin
      st_r[0] <= acc;
      st_r[1] <= st_r[0];
      if (!rst_n) begin
        st_r[0].vld <= 1'b0;
        st_r[1].vld <= 1'b0;
      end
    end

    for (genvar k = 0; k < DIGITS; k++) begin : g_digit
      logic [63:0]                        x_in;
      logic [ORDER_W-1:0]                 r_in;
      bbt_sc_t                            s_in;
      logic [DIGIT_VAL_W-1:0]             val;
      logic [DIGIT_VAL_W+RECIP_SHIFT:0]   scaled;
      logic [DIGIT_W-1:0]                 qd;
      logic [DIGIT_VAL_W-1:0]             back;
      logic [DIGIT_VAL_W-1:0]             rem;

      // Next digit of the quotient by a reciprocal multiplication; it is
      // shifted into the term as it goes.
      always_comb begin
        if (k == 0) begin
          x_in = prod[125:62];
          r_in = '0;
          s_in = st_r[1];
          s_in.t = '0;
        end else begin
          x_in = x_r[k-1];
          r_in = rem_r[k-1];
          s_in = dg_r[k-1];
        end
        val    = {r_in, x_in[63 - DIGIT_W * k -: DIGIT_W]};
        scaled = val * RECIP;
        qd     = scaled[RECIP_SHIFT +: DIGIT_W];
        back   = DIGIT_VAL_W'(qd) * ORDER;
        rem    = val - back;
        s_in.t = {s_in.t[63-DIGIT_W:0], qd};
      end

      always_ff @(posedge clk) begin
        x_r[k]     <= x_in;
        rem_r[k]   <= rem[ORDER_W-1:0];
        dg_r[k]    <= s_in;
        if (!rst_n) begin
          dg_r[k].vld <= 1'b0;
        end
      end
    end

    assign link[g] = dg_r[DIGITS-1];
  end

  // The last term joins its series here.
  always_comb begin
    fin_nxt = link[SERIES_ORDER];
    case (FINAL_PHASE)
      1:       fin_nxt.sa = link[SERIES_ORDER].sa + link[SERIES_ORDER].t;
      2:       fin_nxt.ca = link[SERIES_ORDER].ca - link[SERIES_ORDER].t;
      3:       fin_nxt.sa = link[SERIES_ORDER].sa - link[SERIES_ORDER].t;
      default: fin_nxt.ca = link[SERIES_ORDER].ca + link[SERIES_ORDER].t;
    endcase
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
    if (!rst_n) begin
      fin_r.vld <= 1'b0;
    end
  end

  assign out_vld  = fin_r.vld;
  assign sin_q    = fin_r.sa;
  assign cos_q    = fin_r.ca;
  assign out_coef = fin_r.coef;

endmodule

// File: rtl/core/bbt_combine.sv
// ----------------------------------------------------------------------------
// bbt_combine
// Scales the s-domain coefficients by sin^2, sin*cos and cos^2 and forms the
// five numerators and the denominator of the z-domain section.
// ----------------------------------------------------------------------------
module bbt_combine import bbt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] sin_q,
  input  logic [63:0] cos_q,
  input  bbt_in_t     in_coef,
  output bbt_frac_t   frac
);

  typedef struct packed {
    logic                                vld;
    logic [NUM_COEF-1:0][COEF_WIDTH-1:0] mag;
    logic [NUM_COEF-1:0]                 neg;
    logic [63:0]                         ss;
  } bbt_cb_t;

  logic [127:0]                        ss_prod;
  logic [127:0]                        cs_prod;
  logic [127:0]                        cc_prod;
  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] raw;
  bbt_cb_t                             c0;
  bbt_cb_t                             st_r [4];
  logic [63:0]                         weight [NUM_COEF];
  logic [127:0]                        tp [NUM_COEF];
  logic signed [TERM_W-1:0]            term_nxt [NUM_COEF + 1];
  logic signed [TERM_W-1:0]            term_r [NUM_COEF + 1];
  logic                                term_vld_r;
  logic signed [SUM_W-1:0]             e [NUM_COEF + 1];
  logic signed [SUM_W-1:0]             d_num;
  logic signed [SUM_W-1:0]             d_den;
  bbt_frac_t                           frac_nxt;
  bbt_frac_t                           frac_r;

  // Squares and cross product of sine and cosine.
  bbt_mul64 u_ss (.clk(clk), .a(sin_q), .b(sin_q), .p(ss_prod));
  bbt_mul64 u_cs (.clk(clk), .a(cos_q), .b(sin_q), .p(cs_prod));
  bbt_mul64 u_cc (.clk(clk), .a(cos_q), .b(cos_q), .p(cc_prod));

  // Sign and magnitude of each incoming coefficient.
  always_comb begin
    raw = {in_coef.s_den2, in_coef.s_den1, in_coef.s_num2, in_coef.s_num1,
           in_coef.s_num0};
    c0 = '0;
    c0.vld = in_vld;
    for (int i = 0; i < NUM_COEF; i++) begin
      c0.neg[i] = raw[i][COEF_WIDTH-1];
      c0.mag[i] = raw[i][COEF_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
    end
  end

  always_ff @(posedge clk) begin
    st_r[0]    <= c0;
    st_r[1]    <= st_r[0];
    st_r[2]    <= '{vld: st_r[1].vld, mag: st_r[1].mag, neg: st_r[1].neg,
                    ss: ss_prod[125:62]};
    st_r[3]    <= st_r[2];
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
      st_r[1].vld <= 1'b0;
      st_r[2].vld <= 1'b0;
      st_r[3].vld <= 1'b0;
    end
  end

  // b0 takes sin^2, b1 and a1 take sin*cos, b2 and a2 take cos^2.
  assign weight[0] = ss_prod[125:62];
  assign weight[1] = cs_prod[125:62];
  assign weight[2] = cc_prod[125:62];
  assign weight[3] = cs_prod[125:62];
  assign weight[4] = cc_prod[125:62];

  for (genvar i = 0; i < NUM_COEF; i++) begin : g_term
    bbt_mul64 u_term (
      .clk (clk),
      .a   (64'(st_r[1].mag[i])),
      .b   (weight[i]),
      .p   (tp[i])
    );
  end

  // Signed terms, with the constant one scaled by sin^2 as the last.
  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      term_nxt[i] = st_r[3].neg[i] ? -$signed({1'b0, tp[i][PROD_W-1:0]})
                                   : $signed({1'b0, tp[i][PROD_W-1:0]});
    end
    term_nxt[NUM_COEF] = $signed(TERM_W'({st_r[3].ss, {IN_FRAC{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    term_r     <= term_nxt;
    term_vld_r <= st_r[3].vld;
    if (!rst_n) begin
      term_vld_r <= 1'b0;
    end
  end

  // Numerators and denominator.
  always_comb begin
    for (int i = 0; i <= NUM_COEF; i++) begin
      e[i] = SUM_W'(term_r[i]);
    end
    d_num = e[0] - e[2];
    d_den = e[5] - e[4];
    frac_nxt.vld    = term_vld_r;
    frac_nxt.num[0] = e[0] + e[1] + e[2];
    frac_nxt.num[1] = d_num + d_num;
    frac_nxt.num[2] = e[0] - e[1] + e[2];
    frac_nxt.num[3] = d_den + d_den;
    frac_nxt.num[4] = e[5] - e[3] + e[4];
    frac_nxt.den    = e[5] + e[3] + e[4];
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
    if (!rst_n) begin
      frac_r.vld <= 1'b0;
    end
  end

  assign frac = frac_r;

endmodule

// File: rtl/core/bbt_divider.sv
// ----------------------------------------------------------------------------
// bbt_divider
// Five-lane pipelined restoring divider, one quotient bit per stage, with
// rounding, saturation and the zero-denominator case in the last stage.
// ----------------------------------------------------------------------------
module bbt_divider import bbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bbt_frac_t frac,
  output logic      out_vld,
  output bbt_out_t  out_data
);

  typedef struct packed {
    logic [SUM_W-1:0]  nm;
    logic [SUM_W-1:0]  rm;
    logic [QUOT_W-1:0] q;
    logic              neg;
  } bbt_lane_t;

  typedef struct packed {
    logic                           vld;
    logic                           zero;
    logic [SUM_W-1:0]               dm;
    bbt_lane_t [NUM_COEF-1:0]       lane;
  } bbt_div_t;

  localparam logic [QUOT_W-2:0] HALF_LIMIT = (QUOT_W - 1)'(1) << (COEF_WIDTH - 1);

  bbt_div_t                            entry;
  bbt_div_t                            it_r [DIV_ITER + 1];
  logic [QUOT_W-1:0]                   q_inc;
  logic [QUOT_W-2:0]                   m;
  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] z;
  logic                                sat;
  bbt_out_t                            out_nxt;
  bbt_out_t                            out_r;
  logic                                out_vld_r;

  // Magnitudes and quotient signs.
  always_comb begin
    entry      = '0;
    entry.vld  = frac.vld;
    entry.zero = (frac.den == '0);
    entry.dm   = frac.den[SUM_W-1] ? (~frac.den + 1'b1) : frac.den;
    for (int i = 0; i < NUM_COEF; i++) begin
      entry.lane[i].nm  = frac.num[i][SUM_W-1] ? (~frac.num[i] + 1'b1) : frac.num[i];
      entry.lane[i].neg = frac.num[i][SUM_W-1] ^ frac.den[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    it_r[0] <= entry;
    if (!rst_n) begin
      it_r[0].vld <= 1'b0;
    end
  end

  // One numerator bit enters each stage; the quotient is clamped so that a
  // large result stays just above the saturation limit.
  for (genvar j = 0; j < DIV_ITER; j++) begin : g_iter
    bbt_div_t          nxt;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;
    logic              ge;
    logic [QUOT_W-1:0] qs;

    always_comb begin
      nxt   = it_r[j];
      trial = '0;
      diff  = '0;
      ge    = 1'b0;
      qs    = '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        trial = {it_r[j].lane[i].rm, it_r[j].lane[i].nm[SUM_W-1]};
        diff  = trial - {1'b0, it_r[j].dm};
        ge    = (trial >= {1'b0, it_r[j].dm});
        nxt.lane[i].rm = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        nxt.lane[i].nm = {it_r[j].lane[i].nm[SUM_W-2:0], 1'b0};
        qs = {it_r[j].lane[i].q[QUOT_W-2:0], ge};
        nxt.lane[i].q = (qs > QUOT_CAP) ? QUOT_CAP : qs;
      end
    end

    always_ff @(posedge clk) begin
      it_r[j+1] <= nxt;
      if (!rst_n) begin
        it_r[j+1].vld <= 1'b0;
      end
    end
  end

  // Round half away from zero, saturate and build the result beat.
  always_comb begin
    sat   = 1'b0;
    z     = '0;
    q_inc = '0;
    m     = '0;
    for (int i = 0; i < NUM_COEF; i++) begin
      q_inc = it_r[DIV_ITER].lane[i].q + 1'b1;
      m     = q_inc[QUOT_W-1:1];
      if (it_r[DIV_ITER].lane[i].neg) begin
        if (m > HALF_LIMIT) begin
          m   = HALF_LIMIT;
          sat = 1'b1;
        end
        z[i] = ~m[COEF_WIDTH-1:0] + 1'b1;
      end else begin
        if (m > HALF_LIMIT - 1'b1) begin
          m   = HALF_LIMIT - 1'b1;
          sat = 1'b1;
        end
        z[i] = m[COEF_WIDTH-1:0];
      end
    end
    if (it_r[DIV_ITER].zero) begin
      z   = '0;
      out_nxt.status = STAT_ZERO_DEN;
    end else if (sat) begin
      out_nxt.status = STAT_SAT;
    end else begin
      out_nxt.status = STAT_OK;
    end
    out_nxt.z_num0 = z[0];
    out_nxt.z_num1 = z[1];
    out_nxt.z_num2 = z[2];
    out_nxt.z_den1 = z[3];
    out_nxt.z_den2 = z[4];
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    out_vld_r <= it_r[DIV_ITER].vld;
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  // A zero denominator clears every coefficient.
  a_zero_den_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == STAT_ZERO_DEN) |->
      (out_r.z_num0 == '0 && out_r.z_num1 == '0 && out_r.z_num2 == '0 &&
       out_r.z_den1 == '0 && out_r.z_den2 == '0))
    else $error("zero denominator beat with non-zero coefficients");

  // A saturation flag needs at least one coefficient at a limit.
  a_sat_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == STAT_SAT) |->
      (out_r.z_num0 == COEF_MAX || out_r.z_num0 == COEF_MIN ||
       out_r.z_num1 == COEF_MAX || out_r.z_num1 == COEF_MIN ||
       out_r.z_num2 == COEF_MAX || out_r.z_num2 == COEF_MIN ||
       out_r.z_den1 == COEF_MAX || out_r.z_den1 == COEF_MIN ||
       out_r.z_den2 == COEF_MAX || out_r.z_den2 == COEF_MIN))
    else $error("saturation flagged without a clamped coefficient");
`endif

endmodule

// File: rtl/core/biquad_bilinear_transform_unit.sv
// ----------------------------------------------------------------------------
// biquad_bilinear_transform_unit
// The delay from the accepting edge to the result strobe is set by
// the 25-term sine and cosine series (six stages a term) and the divider
// (one quotient bit a stage). Throughput: one item per cycle; busy is high
// only while reset is held. Reset clears only the valid bits of the pipeline
// and no beat is taken until it is released.
// ----------------------------------------------------------------------------
module biquad_bilinear_transform_unit import bbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bbt_in_t  in_data,
  output logic     out_valid,
  output bbt_out_t out_data
);

  logic        accept;
  logic        sc_vld;
  logic [63:0] sc_sin;
  logic [63:0] sc_cos;
  bbt_in_t     sc_coef;
  bbt_frac_t   frac;

  // The pipeline advances every cycle, so a beat with start high is taken
  // whenever reset is released.
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  bbt_sincos u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_coef  (in_data),
    .out_vld  (sc_vld),
    .sin_q    (sc_sin),
    .cos_q    (sc_cos),
    .out_coef (sc_coef)
  );

  bbt_combine u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sc_vld),
    .sin_q   (sc_sin),
    .cos_q   (sc_cos),
    .in_coef (sc_coef),
    .frac    (frac)
  );

  bbt_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .frac     (frac),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // Every result strobe answers a beat taken a fixed latency earlier.
  a_result_follows_beat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LATENCY))
    else $error("result strobe without a matching input beat");
`endif

endmodule
